// ===== rtl/core/rra_pkg.sv =====
// Shared types and constants for the register-type ALU with HI/LO.
// Used by rra_ram's users, rra_regfile, rra_muldiv and the top level.
// No dependencies.
package rra_pkg;

    localparam int XLEN     = 32;
    localparam int NUM_REGS = 32;
    localparam int RIDX_W   = 5;
    localparam int FUNCT_W  = 6;
    localparam int SHAMT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int MD_STEPS = 32;
    localparam int STEP_W   = 5;

    // Function codes
    localparam logic [FUNCT_W-1:0] FN_SLL   = 6'h00;
    localparam logic [FUNCT_W-1:0] FN_SRL   = 6'h02;
    localparam logic [FUNCT_W-1:0] FN_MFHI  = 6'h10;
    localparam logic [FUNCT_W-1:0] FN_MTHI  = 6'h11;
    localparam logic [FUNCT_W-1:0] FN_MFLO  = 6'h12;
    localparam logic [FUNCT_W-1:0] FN_MTLO  = 6'h13;
    localparam logic [FUNCT_W-1:0] FN_MULT  = 6'h18;
    localparam logic [FUNCT_W-1:0] FN_MULTU = 6'h19;
    localparam logic [FUNCT_W-1:0] FN_DIVU  = 6'h1B;
    localparam logic [FUNCT_W-1:0] FN_ADD   = 6'h20;
    localparam logic [FUNCT_W-1:0] FN_ADDU  = 6'h21;
    localparam logic [FUNCT_W-1:0] FN_SUB   = 6'h22;
    localparam logic [FUNCT_W-1:0] FN_SUBU  = 6'h23;
    localparam logic [FUNCT_W-1:0] FN_AND   = 6'h24;
    localparam logic [FUNCT_W-1:0] FN_OR    = 6'h25;
    localparam logic [FUNCT_W-1:0] FN_XOR   = 6'h26;
    localparam logic [FUNCT_W-1:0] FN_NOR   = 6'h27;

    // Item kinds
    localparam logic KIND_EXEC = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVF   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DIV0  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNSUP = 2'd3;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_EXEC,
        SEQ_MD_WAIT,
        SEQ_FINISH
    } seq_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_RUN,
        MD_FIX,
        MD_DONE
    } md_state_t;

    typedef enum logic {
        MD_MUL,
        MD_DIV
    } md_op_t;

    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] addr;
        logic [XLEN-1:0]   data;
    } rf_wr_t;

    typedef struct packed {
        logic            start;
        md_op_t          op;
        logic            signed_op;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
    } md_req_t;

    typedef struct packed {
        logic            done;
        logic [XLEN-1:0] hi;
        logic [XLEN-1:0] lo;
    } md_rsp_t;

endpackage

// ===== rtl/core/risc_register_alu_with_hi_lo.sv =====
// Register-type ALU with HI/LO: executes one decoded instruction per item.
// Input channel s_* carries an instruction or a register load; result channel
// m_* returns one result per item: the register write (if any), HI, LO, status.
// A transfer happens on a rising aclk edge with valid and ready both high.
// s_ready is high only while the sequencer is idle; one item is in work at a time.
// Register operands are read from the RAM-based register file on the accept edge.
// Simple operations go through the execute and finish steps before m_valid rises,
// and the next input transfer waits until the sequencer is back in idle. MULTU, DIVU
// and MULT of operands with equal signs wait in the sequencer's muldiv step while
// the shared 33-bit adder in rra_muldiv makes 32 passes, one bit per cycle.
// MULT of operands with opposite signs takes an extra step for the final
// negation; DIVU by a zero divisor takes the simple path.
// Results sit in an output register; a stalled receiver holds the sequencer in
// its finish step until the output register is taken, the next item waits.
// aresetn (synchronous, active low) makes all registers read as zero, zeroes HI
// and LO, clears m_valid and returns the sequencer to idle, so s_ready is high
// from the first reset edge on. Register 0 always reads zero.
// Depends on rra_pkg, rra_regfile, rra_muldiv.
module risc_register_alu_with_hi_lo (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_kind,
    input  logic [rra_pkg::FUNCT_W-1:0]    s_funct,
    input  logic [rra_pkg::RIDX_W-1:0]     s_src_a,
    input  logic [rra_pkg::RIDX_W-1:0]     s_src_b,
    input  logic [rra_pkg::RIDX_W-1:0]     s_dest,
    input  logic [rra_pkg::SHAMT_W-1:0]    s_shift_amount,
    input  logic [rra_pkg::XLEN-1:0]       s_load_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_write_done,
    output logic [rra_pkg::RIDX_W-1:0]     m_write_index,
    output logic [rra_pkg::XLEN-1:0]       m_write_value,
    output logic [rra_pkg::XLEN-1:0]       m_hi_value,
    output logic [rra_pkg::XLEN-1:0]       m_lo_value,
    output logic [rra_pkg::STATUS_W-1:0]   m_status
);

    rra_pkg::seq_state_t              state_reg, state_next;

    logic                             kind_reg;
    logic [rra_pkg::FUNCT_W-1:0]      funct_reg;
    logic [rra_pkg::RIDX_W-1:0]       dest_reg;
    logic [rra_pkg::SHAMT_W-1:0]      shamt_reg;
    logic [rra_pkg::XLEN-1:0]         load_reg;

    logic [rra_pkg::XLEN-1:0]         hi_reg;
    logic [rra_pkg::XLEN-1:0]         lo_reg;

    logic                             res_wr_reg;
    logic [rra_pkg::RIDX_W-1:0]       res_idx_reg;
    logic [rra_pkg::XLEN-1:0]         res_val_reg;
    logic [rra_pkg::STATUS_W-1:0]     res_status_reg;

    logic                             m_valid_reg;
    logic                             m_write_done_reg;
    logic [rra_pkg::RIDX_W-1:0]       m_write_index_reg;
    logic [rra_pkg::XLEN-1:0]         m_write_value_reg;
    logic [rra_pkg::XLEN-1:0]         m_hi_value_reg;
    logic [rra_pkg::XLEN-1:0]         m_lo_value_reg;
    logic [rra_pkg::STATUS_W-1:0]     m_status_reg;

    logic                             s_accept;
    logic                             out_load;
    logic [rra_pkg::XLEN-1:0]         op_a;
    logic [rra_pkg::XLEN-1:0]         op_b;
    logic [rra_pkg::XLEN-1:0]         sum;
    logic [rra_pkg::XLEN-1:0]         diff;

    logic                             wr_c;
    logic [rra_pkg::XLEN-1:0]         val_c;
    logic [rra_pkg::STATUS_W-1:0]     status_c;
    logic [rra_pkg::XLEN-1:0]         hi_c;
    logic [rra_pkg::XLEN-1:0]         lo_c;

    rra_pkg::rf_wr_t                  rf_wr;
    rra_pkg::md_req_t                 md_req;
    rra_pkg::md_rsp_t                 md_rsp;

    assign s_accept = s_valid && s_ready;
    assign s_ready  = (state_reg == rra_pkg::SEQ_IDLE);
    assign out_load = (state_reg == rra_pkg::SEQ_FINISH) && (!m_valid_reg || m_ready);

    rra_regfile u_regfile (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (rf_wr),
        .rd_en    (s_accept),
        .rd_addr_a(s_src_a),
        .rd_addr_b(s_src_b),
        .rd_data_a(op_a),
        .rd_data_b(op_b)
    );

    rra_muldiv u_muldiv (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (md_req),
        .rsp    (md_rsp)
    );

    assign sum  = op_a + op_b;
    assign diff = op_a - op_b;

    // Decode the item, execute the simple operations and start multiply/divide
    always_comb begin
        wr_c          = 1'b0;
        val_c         = '0;
        status_c      = rra_pkg::STATUS_OK;
        hi_c          = hi_reg;
        lo_c          = lo_reg;
        md_req.start  = 1'b0;
        md_req.op     = rra_pkg::MD_MUL;
        md_req.signed_op = 1'b0;
        md_req.a      = op_a;
        md_req.b      = op_b;
        if (kind_reg == rra_pkg::KIND_LOAD) begin
            wr_c  = 1'b1;
            val_c = load_reg;
        end else begin
            unique case (funct_reg) inside
                rra_pkg::FN_ADD: begin
                    val_c = sum;
                    if ((~(op_a ^ op_b) & (op_a ^ sum)) >> (rra_pkg::XLEN - 1) != '0) begin
                        status_c = rra_pkg::STATUS_OVF;
                    end else begin
                        wr_c = 1'b1;
                    end
                end
                rra_pkg::FN_SUB: begin
                    val_c = diff;
                    if (((op_a ^ op_b) & (op_a ^ diff)) >> (rra_pkg::XLEN - 1) != '0) begin
                        status_c = rra_pkg::STATUS_OVF;
                    end else begin
                        wr_c = 1'b1;
                    end
                end
                rra_pkg::FN_ADDU: begin wr_c = 1'b1; val_c = sum;  end
                rra_pkg::FN_SUBU: begin wr_c = 1'b1; val_c = diff; end
                rra_pkg::FN_AND:  begin wr_c = 1'b1; val_c = op_a & op_b; end
                rra_pkg::FN_OR:   begin wr_c = 1'b1; val_c = op_a | op_b; end
                rra_pkg::FN_XOR:  begin wr_c = 1'b1; val_c = op_a ^ op_b; end
                rra_pkg::FN_NOR:  begin wr_c = 1'b1; val_c = ~(op_a | op_b); end
                rra_pkg::FN_SLL:  begin wr_c = 1'b1; val_c = op_b << shamt_reg; end
                rra_pkg::FN_SRL:  begin wr_c = 1'b1; val_c = op_b >> shamt_reg; end
                rra_pkg::FN_MFHI: begin wr_c = 1'b1; val_c = hi_reg; end
                rra_pkg::FN_MFLO: begin wr_c = 1'b1; val_c = lo_reg; end
                rra_pkg::FN_MTHI: hi_c = op_a;
                rra_pkg::FN_MTLO: lo_c = op_a;
                rra_pkg::FN_MULT, rra_pkg::FN_MULTU: begin
                    md_req.start     = (state_reg == rra_pkg::SEQ_EXEC);
                    md_req.signed_op = (funct_reg == rra_pkg::FN_MULT);
                end
                rra_pkg::FN_DIVU: begin
                    if (op_b == '0) begin
                        status_c = rra_pkg::STATUS_DIV0;
                    end else begin
                        md_req.start = (state_reg == rra_pkg::SEQ_EXEC);
                        md_req.op    = rra_pkg::MD_DIV;
                    end
                end
                default: status_c = rra_pkg::STATUS_UNSUP;
            endcase
        end
        // drop writes to register 0
        if (dest_reg == '0) begin
            wr_c = 1'b0;
        end
    end

    assign rf_wr.en   = (state_reg == rra_pkg::SEQ_EXEC) && wr_c;
    assign rf_wr.addr = dest_reg;
    assign rf_wr.data = val_c;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rra_pkg::SEQ_IDLE: if (s_valid) state_next = rra_pkg::SEQ_EXEC;
            rra_pkg::SEQ_EXEC: begin
                state_next = md_req.start ? rra_pkg::SEQ_MD_WAIT : rra_pkg::SEQ_FINISH;
            end
            rra_pkg::SEQ_MD_WAIT: if (md_rsp.done) state_next = rra_pkg::SEQ_FINISH;
            rra_pkg::SEQ_FINISH:  if (!m_valid_reg || m_ready) state_next = rra_pkg::SEQ_IDLE;
            default:              state_next = rra_pkg::SEQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rra_pkg::SEQ_IDLE;
            hi_reg      <= '0;
            lo_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == rra_pkg::SEQ_EXEC) begin
                hi_reg <= hi_c;
                lo_reg <= lo_c;
            end else if (state_reg == rra_pkg::SEQ_MD_WAIT && md_rsp.done) begin
                hi_reg <= md_rsp.hi;
                lo_reg <= md_rsp.lo;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: item fields, per-item result, output stage
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg  <= s_kind;
            funct_reg <= s_funct;
            dest_reg  <= s_dest;
            shamt_reg <= s_shift_amount;
            load_reg  <= s_load_value;
        end
        if (state_reg == rra_pkg::SEQ_EXEC) begin
            res_wr_reg     <= wr_c;
            res_idx_reg    <= wr_c ? dest_reg : '0;
            res_val_reg    <= wr_c ? val_c : '0;
            res_status_reg <= status_c;
        end
        if (out_load) begin
            m_write_done_reg  <= res_wr_reg;
            m_write_index_reg <= res_idx_reg;
            m_write_value_reg <= res_val_reg;
            m_hi_value_reg    <= hi_reg;
            m_lo_value_reg    <= lo_reg;
            m_status_reg      <= res_status_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_write_done  = m_write_done_reg;
    assign m_write_index = m_write_index_reg;
    assign m_write_value = m_write_value_reg;
    assign m_hi_value    = m_hi_value_reg;
    assign m_lo_value    = m_lo_value_reg;
    assign m_status      = m_status_reg;

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
        else $error("input taken while an item is in work");

    a_no_write_to_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_wr.en |-> rf_wr.addr != '0)
        else $error("register 0 written");

    a_md_start_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        md_req.start |=> state_reg == rra_pkg::SEQ_MD_WAIT)
        else $error("muldiv started outside the execute step");

    a_fault_means_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != rra_pkg::STATUS_OK
            && m_write_done_reg |-> 1'b0)
        else $error("faulting item reported a register write");

endmodule

// ===== rtl/core/rra_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module rra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== rtl/core/rra_regfile.sv =====
// Register file: RAM plus per-entry valid bits so reset reads as zero.
// Register 0 always reads zero. Depends on rra_pkg and rra_ram.
module rra_regfile (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rra_pkg::rf_wr_t             wr,
    input  logic                        rd_en,
    input  logic [rra_pkg::RIDX_W-1:0]  rd_addr_a,
    input  logic [rra_pkg::RIDX_W-1:0]  rd_addr_b,
    output logic [rra_pkg::XLEN-1:0]    rd_data_a,
    output logic [rra_pkg::XLEN-1:0]    rd_data_b
);

    logic [rra_pkg::NUM_REGS-1:0] valid_reg;
    logic                         ok_a_reg;
    logic                         ok_b_reg;
    logic [rra_pkg::XLEN-1:0]     ram_a;
    logic [rra_pkg::XLEN-1:0]     ram_b;

    rra_ram #(
        .WIDTH(rra_pkg::XLEN),
        .DEPTH(rra_pkg::NUM_REGS)
    ) u_ram (
        .aclk     (aclk),
        .wr_en    (wr.en),
        .wr_addr  (wr.addr),
        .wr_data  (wr.data),
        .rd_en    (rd_en),
        .rd_addr_a(rd_addr_a),
        .rd_addr_b(rd_addr_b),
        .rd_data_a(ram_a),
        .rd_data_b(ram_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            ok_a_reg  <= 1'b0;
            ok_b_reg  <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                ok_a_reg <= valid_reg[rd_addr_a] && (rd_addr_a != '0);
                ok_b_reg <= valid_reg[rd_addr_b] && (rd_addr_b != '0);
            end
        end
    end

    assign rd_data_a = ok_a_reg ? ram_a : '0;
    assign rd_data_b = ok_b_reg ? ram_b : '0;

endmodule

// ===== rtl/core/rra_muldiv.sv =====
// Iterative multiply/divide unit: one shared 33-bit adder, one bit per cycle.
// Shift-add multiply (signed via magnitudes) and restoring unsigned divide.
// Depends on rra_pkg.
module rra_muldiv (
    input  logic             aclk,
    input  logic             aresetn,
    input  rra_pkg::md_req_t req,
    output rra_pkg::md_rsp_t rsp
);

    rra_pkg::md_state_t          state_reg, state_next;
    rra_pkg::md_op_t             op_reg;
    logic                        neg_reg;
    logic [rra_pkg::STEP_W-1:0]  count_reg;
    logic [rra_pkg::XLEN-1:0]    opnd_reg;
    logic [rra_pkg::XLEN:0]      acc_hi_reg;
    logic [rra_pkg::XLEN-1:0]    acc_lo_reg;

    logic [rra_pkg::XLEN-1:0]    a_mag;
    logic [rra_pkg::XLEN-1:0]    b_mag;
    logic [rra_pkg::XLEN:0]      add_a;
    logic [rra_pkg::XLEN:0]      add_b;
    logic                        add_sub;
    logic [rra_pkg::XLEN+1:0]    add_res;
    logic [2*rra_pkg::XLEN-1:0]  neg_prod;
    logic                        last_step;

    assign a_mag = (req.signed_op && req.a[rra_pkg::XLEN-1]) ? (~req.a + 1'b1) : req.a;
    assign b_mag = (req.signed_op && req.b[rra_pkg::XLEN-1]) ? (~req.b + 1'b1) : req.b;

    // Shared adder: add partial product, or trial-subtract the divisor
    always_comb begin
        if (op_reg == rra_pkg::MD_DIV) begin
            add_a   = {acc_hi_reg[rra_pkg::XLEN-1:0], acc_lo_reg[rra_pkg::XLEN-1]};
            add_b   = {1'b0, opnd_reg};
            add_sub = 1'b1;
        end else begin
            add_a   = acc_hi_reg;
            add_b   = acc_lo_reg[0] ? {1'b0, opnd_reg} : '0;
            add_sub = 1'b0;
        end
        add_res = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                + {{(rra_pkg::XLEN+1){1'b0}}, add_sub};
    end

    assign neg_prod  = ~{acc_hi_reg[rra_pkg::XLEN-1:0], acc_lo_reg} + 1'b1;
    assign last_step = (count_reg == rra_pkg::STEP_W'(rra_pkg::MD_STEPS - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rra_pkg::MD_IDLE: if (req.start) state_next = rra_pkg::MD_RUN;
            rra_pkg::MD_RUN: begin
                if (last_step) begin
                    state_next = neg_reg ? rra_pkg::MD_FIX : rra_pkg::MD_DONE;
                end
            end
            rra_pkg::MD_FIX:  state_next = rra_pkg::MD_DONE;
            rra_pkg::MD_DONE: state_next = rra_pkg::MD_IDLE;
            default:          state_next = rra_pkg::MD_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rra_pkg::MD_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == rra_pkg::MD_IDLE && req.start) begin
            op_reg     <= req.op;
            neg_reg    <= req.signed_op && (req.a[rra_pkg::XLEN-1] ^ req.b[rra_pkg::XLEN-1]);
            count_reg  <= '0;
            opnd_reg   <= b_mag;
            acc_lo_reg <= a_mag;
            acc_hi_reg <= '0;
        end else if (state_reg == rra_pkg::MD_RUN) begin
            count_reg <= count_reg + 1'b1;
            if (op_reg == rra_pkg::MD_DIV) begin
                // keep the trial difference when it did not borrow
                if (add_res[rra_pkg::XLEN+1]) begin
                    acc_hi_reg <= add_res[rra_pkg::XLEN:0];
                end else begin
                    acc_hi_reg <= add_a;
                end
                acc_lo_reg <= {acc_lo_reg[rra_pkg::XLEN-2:0], add_res[rra_pkg::XLEN+1]};
            end else begin
                acc_hi_reg <= {1'b0, add_res[rra_pkg::XLEN:1]};
                acc_lo_reg <= {add_res[0], acc_lo_reg[rra_pkg::XLEN-1:1]};
            end
        end else if (state_reg == rra_pkg::MD_FIX) begin
            acc_hi_reg <= {1'b0, neg_prod[2*rra_pkg::XLEN-1:rra_pkg::XLEN]};
            acc_lo_reg <= neg_prod[rra_pkg::XLEN-1:0];
        end
    end

    assign rsp.done = (state_reg == rra_pkg::MD_DONE);
    assign rsp.hi   = acc_hi_reg[rra_pkg::XLEN-1:0];
    assign rsp.lo   = acc_lo_reg;

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> state_reg == rra_pkg::MD_IDLE)
        else $error("muldiv started while busy");

    a_fix_only_signed: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rra_pkg::MD_FIX |-> neg_reg && op_reg == rra_pkg::MD_MUL)
        else $error("negation pass on unsigned operation");

    a_done_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(rsp.done) |-> $past(state_reg) == rra_pkg::MD_RUN
                         || $past(state_reg) == rra_pkg::MD_FIX)
        else $error("muldiv done without running");

endmodule

// ===== dv/risc_register_alu_with_hi_lo_tb.sv =====
// Testbench for risc_register_alu_with_hi_lo: random and directed instruction and load traffic.
// A built-in predictor models the register file and HI/LO, and each result is checked.
// Depends on rra_pkg and the risc_register_alu_with_hi_lo RTL.
`timescale 1ns / 100ps

module risc_register_alu_with_hi_lo_tb;

    localparam int RANDOM_ITEMS = 1900;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_ITEMS   = 250;
    localparam int DRAIN_CYCLES = 50;

    typedef logic [rra_pkg::XLEN-1:0]    word_t;
    typedef logic [rra_pkg::FUNCT_W-1:0] funct_t;
    typedef logic [rra_pkg::RIDX_W-1:0]  ridx_t;
    typedef logic [rra_pkg::SHAMT_W-1:0] shamt_t;

    // Codes outside the supported set
    localparam funct_t FN_JR     = 6'h08;
    localparam funct_t FN_UNUSED = 6'h3f;

    typedef struct packed {
        logic                         kind;
        funct_t                       funct;
        ridx_t                        src_a;
        ridx_t                        src_b;
        ridx_t                        dest;
        shamt_t                       shift_amount;
        word_t                        load_value;
    } alu_item_t;

    typedef struct packed {
        logic                         write_done;
        ridx_t                        write_index;
        word_t                        write_value;
        word_t                        hi_value;
        word_t                        lo_value;
        logic [rra_pkg::STATUS_W-1:0] status;
    } alu_result_t;

    typedef struct {
        alu_item_t item;
        bit        drain_first;
    } stim_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_kind = 1'b0;
    funct_t                        s_funct = '0;
    ridx_t                         s_src_a = '0;
    ridx_t                         s_src_b = '0;
    ridx_t                         s_dest = '0;
    shamt_t                        s_shift_amount = '0;
    word_t                         s_load_value = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_write_done;
    ridx_t                         m_write_index;
    word_t                         m_write_value;
    word_t                         m_hi_value;
    word_t                         m_lo_value;
    logic [rra_pkg::STATUS_W-1:0]  m_status;

    // Predictor state
    word_t gpr_model [rra_pkg::NUM_REGS];
    word_t hi_model;
    word_t lo_model;

    stim_t       stim_q[$];
    stim_t       next_stim;
    alu_result_t result_due_q[$];
    alu_item_t   driven_item;
    int          n_total = 0;
    int          n_accepted = 0;
    int          n_results = 0;
    int          n_errors = 0;
    int          cycle_cnt = 0;
    int          idle_left = 0;
    int          stall_left = 0;

    funct_t supported_fns [17] = '{
        rra_pkg::FN_SLL, rra_pkg::FN_SRL, rra_pkg::FN_MFHI, rra_pkg::FN_MTHI,
        rra_pkg::FN_MFLO, rra_pkg::FN_MTLO, rra_pkg::FN_MULT, rra_pkg::FN_MULTU,
        rra_pkg::FN_DIVU, rra_pkg::FN_ADD, rra_pkg::FN_ADDU, rra_pkg::FN_SUB,
        rra_pkg::FN_SUBU, rra_pkg::FN_AND, rra_pkg::FN_OR, rra_pkg::FN_XOR,
        rra_pkg::FN_NOR
    };

    risc_register_alu_with_hi_lo uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_funct        (s_funct),
        .s_src_a        (s_src_a),
        .s_src_b        (s_src_b),
        .s_dest         (s_dest),
        .s_shift_amount (s_shift_amount),
        .s_load_value   (s_load_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_done   (m_write_done),
        .m_write_index  (m_write_index),
        .m_write_value  (m_write_value),
        .m_hi_value     (m_hi_value),
        .m_lo_value     (m_lo_value),
        .m_status       (m_status)
    );

    always #5 aclk = ~aclk;

    // Execute one item against the predictor state and return its result.
    function automatic alu_result_t exec_item(input alu_item_t it);
        word_t                      a;
        word_t                      b;
        word_t                      val;
        logic [2*rra_pkg::XLEN-1:0] prod;
        logic                       wr;
        alu_result_t                res;
        a = (it.src_a == '0) ? '0 : gpr_model[it.src_a];
        b = (it.src_b == '0) ? '0 : gpr_model[it.src_b];
        wr = 1'b0;
        val = '0;
        res.status = rra_pkg::STATUS_OK;
        if (it.kind == rra_pkg::KIND_LOAD) begin
            wr = 1'b1;
            val = it.load_value;
        end else begin
            case (it.funct)
                rra_pkg::FN_ADD: begin
                    val = a + b;
                    if (~(a[31] ^ b[31]) & (a[31] ^ val[31])) res.status = rra_pkg::STATUS_OVF;
                    else wr = 1'b1;
                end
                rra_pkg::FN_SUB: begin
                    val = a - b;
                    if ((a[31] ^ b[31]) & (a[31] ^ val[31])) res.status = rra_pkg::STATUS_OVF;
                    else wr = 1'b1;
                end
                rra_pkg::FN_ADDU: begin val = a + b; wr = 1'b1; end
                rra_pkg::FN_SUBU: begin val = a - b; wr = 1'b1; end
                rra_pkg::FN_AND:  begin val = a & b; wr = 1'b1; end
                rra_pkg::FN_OR:   begin val = a | b; wr = 1'b1; end
                rra_pkg::FN_XOR:  begin val = a ^ b; wr = 1'b1; end
                rra_pkg::FN_NOR:  begin val = ~(a | b); wr = 1'b1; end
                rra_pkg::FN_SLL:  begin val = b << it.shift_amount; wr = 1'b1; end
                rra_pkg::FN_SRL:  begin val = b >> it.shift_amount; wr = 1'b1; end
                rra_pkg::FN_MFHI: begin val = hi_model; wr = 1'b1; end
                rra_pkg::FN_MFLO: begin val = lo_model; wr = 1'b1; end
                rra_pkg::FN_MTHI: hi_model = a;
                rra_pkg::FN_MTLO: lo_model = a;
                rra_pkg::FN_MULT: begin
                    // sign-extend to 64 bits; the low 64 bits of the product are exact
                    prod = {{rra_pkg::XLEN{a[31]}}, a} * {{rra_pkg::XLEN{b[31]}}, b};
                    hi_model = prod[63:32];
                    lo_model = prod[31:0];
                end
                rra_pkg::FN_MULTU: begin
                    prod = {{rra_pkg::XLEN{1'b0}}, a} * {{rra_pkg::XLEN{1'b0}}, b};
                    hi_model = prod[63:32];
                    lo_model = prod[31:0];
                end
                rra_pkg::FN_DIVU: begin
                    if (b == '0) begin
                        res.status = rra_pkg::STATUS_DIV0;
                    end else begin
                        hi_model = a % b;
                        lo_model = a / b;
                    end
                end
                default: res.status = rra_pkg::STATUS_UNSUP;
            endcase
        end
        if (it.dest == '0) wr = 1'b0;
        if (wr) gpr_model[it.dest] = val;
        res.write_done  = wr;
        res.write_index = wr ? it.dest : '0;
        res.write_value = wr ? val : '0;
        res.hi_value    = hi_model;
        res.lo_value    = lo_model;
        return res;
    endfunction

    function automatic bit idling_allowed(input int count);
        return (count < n_total - TAIL_ITEMS) && ((count / 150) % 4 != 3);
    endfunction

    // Bias operand values toward the corners that trip overflow and sign handling.
    function automatic word_t pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'h7fff_ffff;
            3: return 32'h8000_0000;
            4: return 32'hffff_ffff;
            5: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // Random bits for every field of an item.
    function automatic alu_item_t noise_item();
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        return noise[$bits(alu_item_t)-1:0];
    endfunction

    task automatic queue_item(input alu_item_t it, input bit drain_first);
        stim_t s;
        s.item = it;
        s.drain_first = drain_first;
        stim_q.push_back(s);
    endtask

    task automatic queue_exec(input funct_t fn, input int ra, input int rb,
                              input int rd, input int sh);
        alu_item_t it;
        it.kind = rra_pkg::KIND_EXEC;
        it.funct = fn;
        it.src_a = ridx_t'(ra);
        it.src_b = ridx_t'(rb);
        it.dest = ridx_t'(rd);
        it.shift_amount = shamt_t'(sh);
        it.load_value = $urandom;
        queue_item(it, 1'b0);
    endtask

    // Other fields carry noise: a load must ignore them.
    task automatic queue_load(input int rd, input word_t v);
        alu_item_t it;
        it = noise_item();
        it.kind = rra_pkg::KIND_LOAD;
        it.dest = ridx_t'(rd);
        it.load_value = v;
        queue_item(it, 1'b0);
    endtask

    function automatic alu_item_t random_item();
        alu_item_t it;
        int        pick;
        it = noise_item();
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            it.kind = rra_pkg::KIND_LOAD;
            it.load_value = pick_word();
        end else begin
            it.kind = rra_pkg::KIND_EXEC;
            if (pick < 93) it.funct = supported_fns[5'($urandom_range(0, 16))];
            else it.funct = funct_t'($urandom_range(0, 63));
        end
        return it;
    endfunction

    // Driver: present queued items, idle in bursts, hold off on drain points.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                result_due_q.push_back(exec_item(driven_item));
                n_accepted++;
                if (idling_allowed(n_accepted) && $urandom_range(0, 5) == 0)
                    idle_left = $urandom_range(1, 10);
            end
            if (!s_valid || s_ready) begin
                if (idle_left != 0) begin
                    idle_left--;
                    s_valid <= 1'b0;
                end else if (stim_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (stim_q[0].drain_first && result_due_q.size() != 0) begin
                    s_valid <= 1'b0;
                end else begin
                    next_stim = stim_q.pop_front();
                    driven_item = next_stim.item;
                    s_kind         <= driven_item.kind;
                    s_funct        <= driven_item.funct;
                    s_src_a        <= driven_item.src_a;
                    s_src_b        <= driven_item.src_b;
                    s_dest         <= driven_item.dest;
                    s_shift_amount <= driven_item.shift_amount;
                    s_load_value   <= driven_item.load_value;
                    s_valid        <= 1'b1;
                end
            end
        end
    end

    // Receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idling_allowed(n_results) && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic compare_field(input string name, input word_t want, input word_t got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Monitor: check each result transfer against the oldest prediction.
    always @(posedge aclk) begin
        alu_result_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (result_due_q.size() == 0) begin
                $display("%0t: result with none expected, expected none, actual %h", $time,
                         {m_write_done, m_write_index, m_write_value, m_hi_value,
                          m_lo_value, m_status});
                n_errors++;
            end else begin
                want = result_due_q.pop_front();
                compare_field("write_done", word_t'(want.write_done), word_t'(m_write_done));
                compare_field("write_index", word_t'(want.write_index),
                              word_t'(m_write_index));
                compare_field("write_value", want.write_value, m_write_value);
                compare_field("hi_value", want.hi_value, m_hi_value);
                compare_field("lo_value", want.lo_value, m_lo_value);
                compare_field("status", word_t'(want.status), word_t'(m_status));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, result_due_q.size());
            $display("** risc_register_alu_with_hi_lo: FAILED **");
            $finish;
        end
    end

    initial begin
        alu_item_t it;
        gpr_model = '{default: '0};
        hi_model = '0;
        lo_model = '0;

        // Directed: corner values, every operation, overflow, zero divisor, dest zero
        queue_load(1, 32'h7fff_ffff);
        queue_load(2, 32'h8000_0000);
        queue_load(3, 32'hffff_ffff);
        queue_load(0, 32'h1234_5678);
        queue_exec(rra_pkg::FN_ADD, 1, 1, 4, 0);
        queue_exec(rra_pkg::FN_ADD, 1, 3, 4, 0);
        queue_exec(rra_pkg::FN_ADDU, 1, 1, 5, 0);
        queue_exec(rra_pkg::FN_SUB, 2, 1, 6, 0);
        queue_exec(rra_pkg::FN_SUBU, 2, 1, 6, 0);
        queue_exec(rra_pkg::FN_AND, 3, 1, 7, 0);
        queue_exec(rra_pkg::FN_OR, 2, 1, 8, 0);
        queue_exec(rra_pkg::FN_XOR, 3, 2, 9, 0);
        queue_exec(rra_pkg::FN_NOR, 1, 0, 10, 0);
        queue_exec(rra_pkg::FN_SLL, 0, 3, 11, 31);
        queue_exec(rra_pkg::FN_SRL, 0, 3, 12, 31);
        queue_exec(rra_pkg::FN_MULT, 2, 2, 0, 0);
        queue_exec(rra_pkg::FN_MFHI, 0, 0, 13, 0);
        queue_exec(rra_pkg::FN_MULTU, 3, 3, 0, 0);
        queue_exec(rra_pkg::FN_MFLO, 0, 0, 14, 0);
        queue_exec(rra_pkg::FN_DIVU, 3, 1, 0, 0);
        queue_exec(rra_pkg::FN_DIVU, 3, 0, 0, 0);
        queue_exec(rra_pkg::FN_MTHI, 1, 0, 0, 0);
        queue_exec(rra_pkg::FN_MTLO, 2, 0, 0, 0);
        queue_exec(FN_JR, 3, 3, 15, 0);
        queue_exec(FN_UNUSED, 3, 3, 15, 31);
        queue_exec(rra_pkg::FN_ADDU, 3, 3, 0, 0);

        // Random: mostly supported operations on register values seeded by loads
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            it = random_item();
            queue_item(it, (i % 400) == 0);
        end
        n_total = stim_q.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_accepted < n_total || result_due_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (result_due_q.size() != 0) n_errors++;

        if (n_errors == 0) begin
            $display("** risc_register_alu_with_hi_lo: PASSED **");
        end else begin
            $display("** risc_register_alu_with_hi_lo: FAILED **");
        end
        $finish;
    end

endmodule
